@@ rtl/core/rm2q_pkg.sv @@
// Package for the rotation-matrix-to-quaternion block.
// Holds shared constants, case codes and width helpers; no dependencies.
package rm2q_pkg;

    // Default number of fraction bits of matrix and quaternion values
    localparam int FRAC_BITS_DEF = 14;

    // Entries of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef logic [1:0] t_case;

    // Branch codes: largest diagonal element or trace
    localparam t_case CASE_M00   = 2'd0;
    localparam t_case CASE_M11   = 2'd1;
    localparam t_case CASE_M22   = 2'd2;
    localparam t_case CASE_TRACE = 2'd3;

    // Signed width of one unnormalized component: ONE plus three elements
    function automatic int cw_of(input int frac_bits);
        return ((frac_bits > 17) ? frac_bits : 17) + 3;
    endfunction

endpackage

@@ rtl/core/rm2q_if.sv @@
// Channel interfaces of the rotation-matrix-to-quaternion block.
// Matrix input channel and quaternion result channel; no dependencies.
interface rm2q_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

interface rm2q_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
    logic signed [15:0] q_w;
    logic [1:0]         chosen_case;
    logic               zero_norm;

    modport source (output valid, q_x, q_y, q_z, q_w, chosen_case, zero_norm,
                    input ready);
    modport sink   (input valid, q_x, q_y, q_z, q_w, chosen_case, zero_norm,
                    output ready);
endinterface

@@ rtl/core/rm2q_front.sv @@
// Front stage: picks Shepperd's branch and forms the unnormalized quaternion.
// Depends on rm2q_pkg and rm2q_in_if.
module rm2q_front import rm2q_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rm2q_in_if.sink                          i_mat,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [4*cw_of(FRAC_BITS)+1:0]    o_data
);
    localparam int CW = cw_of(FRAC_BITS);
    localparam logic signed [CW-1:0] ONE = CW'(64'sd1 <<< FRAC_BITS);

    logic signed [CW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [17:0]   d0, d1, d2, d3, dmax;
    t_case                sel;
    logic signed [CW-1:0] cx, cy, cz, cw;
    logic                 accept;

    logic                 r_vld;
    t_case                r_sel;
    logic signed [CW-1:0] r_cx, r_cy, r_cz, r_cw;

    assign e00 = CW'(i_mat.m00);
    assign e01 = CW'(i_mat.m01);
    assign e02 = CW'(i_mat.m02);
    assign e10 = CW'(i_mat.m10);
    assign e11 = CW'(i_mat.m11);
    assign e12 = CW'(i_mat.m12);
    assign e20 = CW'(i_mat.m20);
    assign e21 = CW'(i_mat.m21);
    assign e22 = CW'(i_mat.m22);

    // Largest of the diagonal and the trace, ties to the lower index
    always_comb begin
        d0   = 18'(i_mat.m00);
        d1   = 18'(i_mat.m11);
        d2   = 18'(i_mat.m22);
        d3   = d0 + d1 + d2;
        sel  = CASE_M00;
        dmax = d0;
        if (d1 > dmax) begin
            sel  = CASE_M11;
            dmax = d1;
        end
        if (d2 > dmax) begin
            sel  = CASE_M22;
            dmax = d2;
        end
        if (d3 > dmax) begin
            sel  = CASE_TRACE;
        end
    end

    // Unnormalized components for the chosen branch
    always_comb begin
        unique case (sel)
            CASE_M00: begin
                cx = ONE + e00 - e11 - e22;
                cy = e01 + e10;
                cz = e02 + e20;
                cw = e12 - e21;
            end
            CASE_M11: begin
                cx = e01 + e10;
                cy = ONE + e11 - e00 - e22;
                cz = e12 + e21;
                cw = e20 - e02;
            end
            CASE_M22: begin
                cx = e02 + e20;
                cy = e12 + e21;
                cz = ONE + e22 - e00 - e11;
                cw = e01 - e10;
            end
            default: begin
                cx = e12 - e21;
                cy = e20 - e02;
                cz = e01 - e10;
                cw = ONE + e00 + e11 + e22;
            end
        endcase
    end

    assign i_mat.ready = !r_vld || i_ready;
    assign accept      = i_mat.valid && i_mat.ready;

    // Holding register toward the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_mat.ready) begin
            r_vld <= i_mat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sel <= sel;
            r_cx  <= cx;
            r_cy  <= cy;
            r_cz  <= cz;
            r_cw  <= cw;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = {r_sel, r_cw, r_cz, r_cy, r_cx};

endmodule

@@ rtl/core/rm2q_queue.sv @@
// Short queue decoupling the front stage from the normalizing back end.
// Depends on rm2q_pkg for its depth.
module rm2q_queue import rm2q_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [0:QUEUE_DEPTH-1];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             push, pop;

    assign o_ready = (r_cnt != (AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_data;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(QUEUE_DEPTH))
        else $error("queue fill level above depth");

endmodule

@@ rtl/core/rm2q_back.sv @@
// Back end: squares, sum, pipelined integer square root and four divider lanes.
// Depends on rm2q_pkg and rm2q_out_if.
module rm2q_back import rm2q_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [4*cw_of(FRAC_BITS)+1:0]    i_data,
    rm2q_out_if.source                       o_quat
);
    localparam int CW  = cw_of(FRAC_BITS);
    localparam int MW  = CW;                 // component magnitude
    localparam int SW  = 2*MW + 2;           // sum of squares
    localparam int NB  = SW / 2;             // root bits, one per stage
    localparam int QW  = FRAC_BITS + 1;      // quotient bits, one per stage
    localparam int NW  = MW + FRAC_BITS + 2; // dividend
    localparam int LIM = (FRAC_BITS < 15) ? (1 << FRAC_BITS) : 32767;

    logic en;

    // Abs stage
    logic             r0_vld;
    logic [MW-1:0]    r0_mag [0:3];
    logic [3:0]       r0_neg;
    t_case            r0_sel;
    // Square stage
    logic             r1_vld;
    logic [2*MW-1:0]  r1_sqr [0:3];
    logic [MW-1:0]    r1_mag [0:3];
    logic [3:0]       r1_neg;
    t_case            r1_sel;
    // Square-root stages
    logic             r_s_vld  [0:NB];
    logic [SW-1:0]    r_s_rem  [0:NB];
    logic [NB-1:0]    r_s_root [0:NB];
    logic [MW-1:0]    r_s_mag  [0:NB][0:3];
    logic [3:0]       r_s_neg  [0:NB];
    t_case            r_s_sel  [0:NB];
    // Divider stages
    logic             r_d_vld  [0:QW];
    logic [NW-1:0]    r_d_rem  [0:QW][0:3];
    logic [QW-1:0]    r_d_q    [0:QW][0:3];
    logic [NB:0]      r_d_den  [0:QW];
    logic [3:0]       r_d_neg  [0:QW];
    t_case            r_d_sel  [0:QW];
    logic             r_d_zero [0:QW];
    // Output register
    logic             r_o_vld;
    logic [15:0]      r_o_q [0:3];
    t_case            r_o_sel;
    logic             r_o_zero;

    // Whole pipe advances when the output slot frees up
    assign en      = !r_o_vld || o_quat.ready;
    assign o_ready = en;

    // Component magnitudes and signs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_vld <= 1'b0;
        else if (en)  r0_vld <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 4; l++) begin
                r0_neg[l] <= i_data[l*CW + CW - 1];
                r0_mag[l] <= i_data[l*CW + CW - 1] ? MW'(-i_data[l*CW +: CW])
                                                    : MW'(i_data[l*CW +: CW]);
            end
            r0_sel <= i_data[4*CW +: 2];
        end
    end

    // Squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (en)  r1_vld <= r0_vld;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 4; l++) begin
                r1_sqr[l] <= r0_mag[l] * r0_mag[l];
                r1_mag[l] <= r0_mag[l];
            end
            r1_neg <= r0_neg;
            r1_sel <= r0_sel;
        end
    end

    // Sum of squares enters the root pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s_vld[0] <= 1'b0;
        else if (en)  r_s_vld[0] <= r1_vld;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_rem[0]  <= SW'(r1_sqr[0]) + SW'(r1_sqr[1])
                         + SW'(r1_sqr[2]) + SW'(r1_sqr[3]);
            r_s_root[0] <= '0;
            for (int l = 0; l < 4; l++) r_s_mag[0][l] <= r1_mag[l];
            r_s_neg[0]  <= r1_neg;
            r_s_sel[0]  <= r1_sel;
        end
    end

    // Integer square root, one root bit per stage from the top
    for (genvar k = 0; k < NB; k++) begin : g_sqrt
        localparam int J = NB - 1 - k;
        logic [SW-1:0] trial;
        logic          fits;

        assign trial = (SW'(r_s_root[k]) << (J + 1)) | (SW'(1) << (2 * J));
        assign fits  = (r_s_rem[k] >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_s_vld[k+1] <= 1'b0;
            else if (en)  r_s_vld[k+1] <= r_s_vld[k];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s_rem[k+1]  <= fits ? (r_s_rem[k] - trial) : r_s_rem[k];
                r_s_root[k+1] <= fits ? (r_s_root[k] | (NB'(1) << J)) : r_s_root[k];
                for (int l = 0; l < 4; l++) r_s_mag[k+1][l] <= r_s_mag[k][l];
                r_s_neg[k+1]  <= r_s_neg[k];
                r_s_sel[k+1]  <= r_s_sel[k];
            end
        end
    end

    // Divider setup: (mag * 2^(F+1) + n) / (2n) gives rounding half away
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_vld[0] <= 1'b0;
        else if (en)  r_d_vld[0] <= r_s_vld[NB];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 4; l++) begin
                r_d_rem[0][l] <= (NW'(r_s_mag[NB][l]) << (FRAC_BITS + 1))
                               + NW'(r_s_root[NB]);
                r_d_q[0][l]   <= '0;
            end
            r_d_den[0]  <= {r_s_root[NB], 1'b0};
            r_d_neg[0]  <= r_s_neg[NB];
            r_d_sel[0]  <= r_s_sel[NB];
            r_d_zero[0] <= (r_s_root[NB] == '0);
        end
    end

    // Restoring division, one quotient bit per stage from the top
    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int I = QW - 1 - k;
        logic [NW-1:0] sub;

        assign sub = NW'(r_d_den[k]) << I;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_d_vld[k+1] <= 1'b0;
            else if (en)  r_d_vld[k+1] <= r_d_vld[k];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int l = 0; l < 4; l++) begin
                    if (r_d_rem[k][l] >= sub) begin
                        r_d_rem[k+1][l] <= r_d_rem[k][l] - sub;
                        r_d_q[k+1][l]   <= r_d_q[k][l] | (QW'(1) << I);
                    end else begin
                        r_d_rem[k+1][l] <= r_d_rem[k][l];
                        r_d_q[k+1][l]   <= r_d_q[k][l];
                    end
                end
                r_d_den[k+1]  <= r_d_den[k];
                r_d_neg[k+1]  <= r_d_neg[k];
                r_d_sel[k+1]  <= r_d_sel[k];
                r_d_zero[k+1] <= r_d_zero[k];
            end
        end
    end

    // Clamp, apply sign, force zeros on a zero norm
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_vld <= 1'b0;
        else if (en)  r_o_vld <= r_d_vld[QW];
    end
    always_ff @(posedge i_clk) begin
        logic [QW-1:0] qc;
        logic [15:0]   mag16;
        if (en) begin
            for (int l = 0; l < 4; l++) begin
                qc    = (r_d_q[QW][l] > QW'(LIM)) ? QW'(LIM) : r_d_q[QW][l];
                mag16 = 16'(qc);
                if (r_d_zero[QW])      r_o_q[l] <= '0;
                else if (r_d_neg[QW][l]) r_o_q[l] <= -mag16;
                else                   r_o_q[l] <= mag16;
            end
            r_o_sel  <= r_d_sel[QW];
            r_o_zero <= r_d_zero[QW];
        end
    end

    assign o_quat.valid       = r_o_vld;
    assign o_quat.q_x         = r_o_q[0];
    assign o_quat.q_y         = r_o_q[1];
    assign o_quat.q_z         = r_o_q[2];
    assign o_quat.q_w         = r_o_q[3];
    assign o_quat.chosen_case = r_o_sel;
    assign o_quat.zero_norm   = r_o_zero;

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_quat.valid && o_quat.zero_norm) |->
        (o_quat.q_x == '0 && o_quat.q_y == '0 && o_quat.q_z == '0 && o_quat.q_w == '0))
        else $error("zero norm with nonzero components");

    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid |->
        (int'(o_quat.q_x) <= LIM && int'(o_quat.q_x) >= -LIM &&
         int'(o_quat.q_w) <= LIM && int'(o_quat.q_w) >= -LIM))
        else $error("component outside clamp range");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_o_vld && !r0_vld)
        else $error("pipeline valid after reset");

endmodule

@@ rtl/core/rotation_matrix_to_quaternion.sv @@
// Top level: rotation matrix (Q2.14) to unit quaternion (Q2.14), Shepperd's method.
// Depends on rm2q_pkg, rm2q_if, rm2q_front, rm2q_queue and rm2q_back.
//
// Usage:
//   i_mat carries the nine matrix elements; a transaction happens when valid
//   and ready are both high. o_quat returns q_x, q_y, q_z, q_w, the chosen
//   branch (0..2 diagonal element, 3 trace) and a zero-norm flag, one result
//   per input, in input order.
//   Throughput: one transaction per cycle while o_quat.ready stays high.
//   Path from input to output: front register, queue, abs, square and sum
//   stages, the root pipeline (one root bit per stage), divider setup, the four
//   divider lanes (one quotient bit per stage) and the output register.
//   A stalled receiver freezes the back-end pipeline; the queue then fills
//   and i_mat.ready falls once it and the front register are full.
//   Reset (synchronous, active low) empties the front, queue and pipeline;
//   no results are pending after it and no clearing pass is needed.
module rotation_matrix_to_quaternion import rm2q_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rm2q_in_if.sink     i_mat,
    rm2q_out_if.source  o_quat
);
    localparam int PW = 4*cw_of(FRAC_BITS) + 2;

    logic          f_valid, f_ready;
    logic [PW-1:0] f_data;
    logic          b_valid, b_ready;
    logic [PW-1:0] b_data;

    rm2q_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (i_mat),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_data  (f_data)
    );

    rm2q_queue #(.WIDTH(PW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_data),
        .o_valid (b_valid),
        .i_ready (b_ready),
        .o_data  (b_data)
    );

    rm2q_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (b_valid),
        .o_ready (b_ready),
        .i_data  (b_data),
        .o_quat  (o_quat)
    );

endmodule
